// File: src/fqlp_pkg.sv
`timescale 1ns / 1ps

package fqlp_pkg;

    localparam int MAX_REQUEST_BYTES_DEF = 4096;
    localparam int COUNT_W               = 13;
    localparam int STATUS_W              = 3;
    localparam int METHOD_W              = 2;
    localparam int S_TDATA_W             = 8;
    localparam int M_TDATA_W             = 48;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_W     = 8'h57;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef enum logic [2:0] {
        PH_METHOD_BEGIN = 3'd0,
        PH_METHOD_END   = 3'd1,
        PH_RES_BEGIN    = 3'd2,
        PH_RES_END      = 3'd3,
        PH_FINAL_LF     = 3'd4,
        PH_DONE         = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_SYMBOL    = 3'd2,
        ERR_AFTER_END = 3'd3,
        ERR_OVERFLOW  = 3'd4
    } err_t;

    localparam logic [2:0] STATUS_PARSING  = 3'd0;
    localparam logic [2:0] STATUS_COMPLETE = 3'd1;

    localparam logic [1:0] METHOD_NONE    = 2'd0;
    localparam logic [1:0] METHOD_SLASH   = 2'd1;
    localparam logic [1:0] METHOD_VERBOSE = 2'd2;

endpackage

// File: src/finger_query_line_parser_unit.sv
`timescale 1ns / 1ps

// finger query line parser: one query byte per word on the slave side, one status word per
// input word on the master side. a byte is registered at the input, then the parser state
// advances by one small transition into the result registers, so a word is taken every cycle
// and its status word is then presented from those registers; the only limit on throughput is
// backpressure from m_tready. tuser high restarts the parser before that byte. counts are
// held internally up to MAX_REQUEST_BYTES and reported modulo 8192. an error (invalid symbol,
// data after the line end, length overflow) sticks until the next restart.

module finger_query_line_parser_unit #(
    parameter int MAX_REQUEST_BYTES = fqlp_pkg::MAX_REQUEST_BYTES_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fqlp_pkg::S_TDATA_W-1:0] s_tdata,  // data_byte
    input  logic [0:0]                     s_tuser,  // start_of_request
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status, method_length, resource_offset, resource_length, bare_lf_seen, bytes_consumed
    output logic [fqlp_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int PW = $clog2(MAX_REQUEST_BYTES + 1);
    localparam int CW = fqlp_pkg::COUNT_W;

    logic             in_valid;
    logic [7:0]       in_byte;
    logic             in_sor;
    logic             move;
    logic             m_tvalid_reg;
    fqlp_pkg::phase_t phase;
    fqlp_pkg::err_t   error_kind;
    logic [PW-1:0]    position;
    logic [PW-1:0]    name_offset;
    logic [PW-1:0]    name_length;
    logic [1:0]       method_count;
    logic             lf_tolerated;
    logic [2:0]       status;

    assign move = in_valid && (!m_tvalid_reg || m_tready);

    fqlp_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser[0]),
        .take     (move),
        .in_valid (in_valid),
        .in_byte  (in_byte),
        .in_sor   (in_sor)
    );

    fqlp_core #(
        .MAX_REQUEST_BYTES (MAX_REQUEST_BYTES),
        .PW                (PW)
    ) u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step_en          (move),
        .data_byte        (in_byte),
        .start_of_request (in_sor),
        .phase            (phase),
        .error_kind       (error_kind),
        .position         (position),
        .name_offset      (name_offset),
        .name_length      (name_length),
        .method_count     (method_count),
        .lf_tolerated     (lf_tolerated)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (move) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_comb begin
        if (error_kind != fqlp_pkg::ERR_NONE) begin
            status = error_kind;
        end else if (phase == fqlp_pkg::PH_DONE) begin
            status = fqlp_pkg::STATUS_COMPLETE;
        end else begin
            status = fqlp_pkg::STATUS_PARSING;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, CW'(position), lf_tolerated, CW'(name_length),
                       CW'(name_offset), method_count, status};

    a_move_fills_out : assert property (@(posedge aclk) disable iff (!aresetn)
        move |=> m_tvalid)
        else $error("result register not loaded after a step");

    a_position_bounded : assert property (@(posedge aclk) disable iff (!aresetn)
        position <= PW'(MAX_REQUEST_BYTES) && name_length <= position
        && name_offset <= position)
        else $error("parser counters out of range");

    a_error_sticky : assert property (@(posedge aclk) disable iff (!aresetn)
        (move && !in_sor && error_kind != fqlp_pkg::ERR_NONE)
        |=> (error_kind == $past(error_kind) && position == $past(position)))
        else $error("error state changed without a restart");

endmodule

// File: src/fqlp_in_reg.sv
`timescale 1ns / 1ps

module fqlp_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tuser,
    input  logic       take,
    output logic       in_valid,
    output logic [7:0] in_byte,
    output logic       in_sor
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       sor_reg;

    assign s_tready = !valid_reg || take;
    assign in_valid = valid_reg;
    assign in_byte  = byte_reg;
    assign in_sor   = sor_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
            sor_reg  <= s_tuser;
        end
    end

endmodule

// File: src/fqlp_core.sv
`timescale 1ns / 1ps

module fqlp_core #(
    parameter int MAX_REQUEST_BYTES = fqlp_pkg::MAX_REQUEST_BYTES_DEF,
    parameter int PW                = $clog2(MAX_REQUEST_BYTES + 1)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  logic [7:0]            data_byte,
    input  logic                  start_of_request,
    output fqlp_pkg::phase_t      phase,
    output fqlp_pkg::err_t        error_kind,
    output logic [PW-1:0]         position,
    output logic [PW-1:0]         name_offset,
    output logic [PW-1:0]         name_length,
    output logic [1:0]            method_count,
    output logic                  lf_tolerated
);

    localparam logic [PW-1:0] MAX_POS = PW'(MAX_REQUEST_BYTES);
    localparam logic [PW-1:0] ONE     = PW'(1);

    fqlp_pkg::phase_t phase_reg,  phase_next;
    fqlp_pkg::err_t   err_reg,    err_next;
    logic [PW-1:0]    pos_reg,    pos_next;
    logic [PW-1:0]    off_reg,    off_next;
    logic [PW-1:0]    len_reg,    len_next;
    logic [1:0]       meth_reg,   meth_next;
    logic             lf_reg,     lf_next;

    assign phase        = phase_reg;
    assign error_kind   = err_reg;
    assign position     = pos_reg;
    assign name_offset  = off_reg;
    assign name_length  = len_reg;
    assign method_count = meth_reg;
    assign lf_tolerated = lf_reg;

    always_comb begin
        if (start_of_request) begin
            phase_next = fqlp_pkg::PH_METHOD_BEGIN;
            err_next   = fqlp_pkg::ERR_NONE;
            pos_next   = '0;
            off_next   = '0;
            len_next   = '0;
            meth_next  = fqlp_pkg::METHOD_NONE;
            lf_next    = 1'b0;
        end else begin
            phase_next = phase_reg;
            err_next   = err_reg;
            pos_next   = pos_reg;
            off_next   = off_reg;
            len_next   = len_reg;
            meth_next  = meth_reg;
            lf_next    = lf_reg;
        end
        if (err_next == fqlp_pkg::ERR_NONE) begin
            if (phase_next == fqlp_pkg::PH_DONE) begin
                err_next = fqlp_pkg::ERR_AFTER_END;
            end else if (pos_next >= MAX_POS) begin
                err_next = fqlp_pkg::ERR_OVERFLOW;
            end else begin
                unique case (phase_next)
                    fqlp_pkg::PH_METHOD_BEGIN: begin
                        if (data_byte == fqlp_pkg::CHAR_CR) begin
                            phase_next = fqlp_pkg::PH_FINAL_LF;
                        end else if (data_byte == fqlp_pkg::CHAR_LF) begin
                            lf_next    = 1'b1;
                            phase_next = fqlp_pkg::PH_DONE;
                        end else if (data_byte == fqlp_pkg::CHAR_SLASH) begin
                            meth_next  = fqlp_pkg::METHOD_SLASH;
                            phase_next = fqlp_pkg::PH_METHOD_END;
                        end else begin
                            off_next   = pos_next;
                            len_next   = ONE;
                            phase_next = fqlp_pkg::PH_RES_END;
                        end
                    end
                    fqlp_pkg::PH_METHOD_END: begin
                        if (data_byte == fqlp_pkg::CHAR_W) begin
                            meth_next  = fqlp_pkg::METHOD_VERBOSE;
                            phase_next = fqlp_pkg::PH_RES_BEGIN;
                        end else begin
                            err_next = fqlp_pkg::ERR_SYMBOL;
                        end
                    end
                    fqlp_pkg::PH_RES_BEGIN: begin
                        if (data_byte == fqlp_pkg::CHAR_CR) begin
                            phase_next = fqlp_pkg::PH_FINAL_LF;
                        end else if (data_byte == fqlp_pkg::CHAR_LF) begin
                            lf_next    = 1'b1;
                            phase_next = fqlp_pkg::PH_DONE;
                        end else if (data_byte != fqlp_pkg::CHAR_SPACE) begin
                            off_next   = pos_next;
                            len_next   = ONE;
                            phase_next = fqlp_pkg::PH_RES_END;
                        end
                    end
                    fqlp_pkg::PH_RES_END: begin
                        if (data_byte == fqlp_pkg::CHAR_CR) begin
                            phase_next = fqlp_pkg::PH_FINAL_LF;
                        end else if (data_byte == fqlp_pkg::CHAR_LF) begin
                            lf_next    = 1'b1;
                            phase_next = fqlp_pkg::PH_DONE;
                        end else begin
                            len_next = len_next + ONE;
                        end
                    end
                    default: begin
                        if (data_byte == fqlp_pkg::CHAR_LF) begin
                            phase_next = fqlp_pkg::PH_DONE;
                        end else begin
                            err_next = fqlp_pkg::ERR_SYMBOL;
                        end
                    end
                endcase
                if (err_next == fqlp_pkg::ERR_NONE) begin
                    pos_next = pos_next + ONE;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= fqlp_pkg::PH_METHOD_BEGIN;
            err_reg   <= fqlp_pkg::ERR_NONE;
            pos_reg   <= '0;
            off_reg   <= '0;
            len_reg   <= '0;
            meth_reg  <= fqlp_pkg::METHOD_NONE;
            lf_reg    <= 1'b0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            err_reg   <= err_next;
            pos_reg   <= pos_next;
            off_reg   <= off_next;
            len_reg   <= len_next;
            meth_reg  <= meth_next;
            lf_reg    <= lf_next;
        end
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import fqlp_pkg::*;

    localparam int MAX_BYTES   = MAX_REQUEST_BYTES_DEF;
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int DRAIN_WAIT  = 20;

    typedef struct {
        logic [7:0] data;
        logic       restart;
    } query_byte_t;

    // m_tdata layout from the highest bit down
    typedef struct packed {
        logic [2:0]  pad;
        logic [12:0] consumed;
        logic        bare_lf;
        logic [12:0] res_len;
        logic [12:0] res_off;
        logic [1:0]  method;
        logic [2:0]  status;
    } status_word_t;

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic [0:0]             s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    query_byte_t  bytes_to_send[$];
    status_word_t status_due[$];
    int           mismatches  = 0;
    int           cycle_count = 0;
    int           words_queued = 0;
    logic         hold_off = 1'b0;
    logic         steady;

    // parser state mirror
    phase_t      cur_phase;
    err_t        cur_error;
    int unsigned line_pos;
    int unsigned name_off;
    int unsigned name_len;
    logic [1:0]  method_seen;
    logic        bare_lf;

    finger_query_line_parser_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    assign steady = (cycle_count % 2000) < 300;

    function automatic void clear_parser();
        cur_phase   = PH_METHOD_BEGIN;
        cur_error   = ERR_NONE;
        line_pos    = 0;
        name_off    = 0;
        name_len    = 0;
        method_seen = METHOD_NONE;
        bare_lf     = 1'b0;
    endfunction

    function automatic bit line_end(logic [7:0] c);
        if (c == CHAR_CR) begin
            cur_phase = PH_FINAL_LF;
            return 1'b1;
        end
        if (c == CHAR_LF) begin
            bare_lf   = 1'b1;
            cur_phase = PH_DONE;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic status_word_t parse_query_byte(logic [7:0] c, logic restart);
        status_word_t w;
        if (restart)
            clear_parser();
        if (cur_error == ERR_NONE) begin
            if (cur_phase == PH_DONE) begin
                cur_error = ERR_AFTER_END;
            end else if (line_pos >= MAX_BYTES) begin
                cur_error = ERR_OVERFLOW;
            end else begin
                case (cur_phase)
                    PH_METHOD_BEGIN: begin
                        if (!line_end(c)) begin
                            if (c == CHAR_SLASH) begin
                                method_seen = METHOD_SLASH;
                                cur_phase   = PH_METHOD_END;
                            end else begin
                                name_off  = line_pos;
                                name_len  = 1;
                                cur_phase = PH_RES_END;
                            end
                        end
                    end
                    PH_METHOD_END: begin
                        if (c == CHAR_W) begin
                            method_seen = METHOD_VERBOSE;
                            cur_phase   = PH_RES_BEGIN;
                        end else begin
                            cur_error = ERR_SYMBOL;
                        end
                    end
                    PH_RES_BEGIN: begin
                        if (!line_end(c) && c != CHAR_SPACE) begin
                            name_off  = line_pos;
                            name_len  = 1;
                            cur_phase = PH_RES_END;
                        end
                    end
                    PH_RES_END: begin
                        if (!line_end(c))
                            name_len++;
                    end
                    default: begin
                        if (c == CHAR_LF)
                            cur_phase = PH_DONE;
                        else
                            cur_error = ERR_SYMBOL;
                    end
                endcase
                if (cur_error == ERR_NONE)
                    line_pos++;
            end
        end
        w = '0;
        if (cur_error != ERR_NONE)
            w.status = cur_error;
        else if (cur_phase == PH_DONE)
            w.status = STATUS_COMPLETE;
        else
            w.status = STATUS_PARSING;
        w.method   = method_seen;
        w.res_off  = name_off[12:0];
        w.res_len  = name_len[12:0];
        w.bare_lf  = bare_lf;
        w.consumed = line_pos[12:0];
        return w;
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (steady)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic void push_byte(logic [7:0] d, logic restart);
        query_byte_t b;
        b.data    = d;
        b.restart = restart;
        bytes_to_send.push_back(b);
        words_queued++;
    endfunction

    function automatic logic [7:0] name_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CHAR_CR || b == CHAR_LF);
        return b;
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 7))
            0: return CHAR_CR;
            1: return CHAR_LF;
            2: return CHAR_SLASH;
            3: return CHAR_W;
            4: return CHAR_SPACE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // sender
    always @(posedge aclk) begin
        query_byte_t  item;
        status_word_t w;
        int           gap_left;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                w = parse_query_byte(s_tdata, s_tuser[0]);
                status_due.push_back(w);
            end
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (bytes_to_send.size() > 0) begin
                item = bytes_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= item.data;
                s_tuser  <= item.restart;
                gap_left = pick_idle();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        status_word_t want;
        status_word_t got;
        int           stall_left;
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = status_word_t'(m_tdata);
                if (status_due.size() == 0) begin
                    $display("%0t: unexpected word, expected none actual %h", $time, m_tdata);
                    mismatches++;
                end else begin
                    want = status_due.pop_front();
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("method_length", 32'(want.method), 32'(got.method));
                    check_field("resource_offset", 32'(want.res_off), 32'(got.res_off));
                    check_field("resource_length", 32'(want.res_len), 32'(got.res_len));
                    check_field("bare_lf_seen", 32'(want.bare_lf), 32'(got.bare_lf));
                    check_field("bytes_consumed", 32'(want.consumed), 32'(got.consumed));
                end
            end
            if (hold_off) begin
                m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall_left = ($urandom_range(0, 3) == 0) ? pick_idle() : 0;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // long receiver hold-off so the parser backs up into the sender
    initial begin
        wait (aresetn);
        repeat (1500) @(posedge aclk);
        hold_off <= 1'b1;
        repeat (400) @(posedge aclk);
        hold_off <= 1'b0;
    end

    initial begin
        int   overflow_words;
        int   n;
        logic first;
        logic [7:0] b;
        clear_parser();
        overflow_words = 0;

        // verbose query with skipped spaces, then bytes after the end
        push_byte(CHAR_SLASH, 1'b1);
        push_byte(CHAR_W, 1'b0);
        push_byte(CHAR_SPACE, 1'b0);
        push_byte(CHAR_SPACE, 1'b0);
        push_byte(8'h61, 1'b0);
        push_byte(8'h62, 1'b0);
        push_byte(CHAR_CR, 1'b0);
        push_byte(CHAR_LF, 1'b0);
        push_byte(8'h78, 1'b0);
        push_byte(8'h79, 1'b0);
        // empty line ended by a bare lf, then by cr lf
        push_byte(CHAR_LF, 1'b1);
        push_byte(CHAR_CR, 1'b1);
        push_byte(CHAR_LF, 1'b0);
        // slash without w
        push_byte(CHAR_SLASH, 1'b1);
        push_byte(8'h78, 1'b0);
        // cr not followed by lf
        push_byte(8'h61, 1'b1);
        push_byte(CHAR_CR, 1'b0);
        push_byte(8'h62, 1'b0);
        // extreme byte values in the name
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(CHAR_LF, 1'b0);
        // verbose with empty name
        push_byte(CHAR_SLASH, 1'b1);
        push_byte(CHAR_W, 1'b0);
        push_byte(CHAR_LF, 1'b0);

        while (words_queued - overflow_words < 1625) begin
            if (overflow_words == 0 && words_queued > 700) begin
                // one request past the length limit
                n = words_queued;
                push_byte(8'h61, 1'b1);
                repeat (MAX_BYTES) push_byte(name_byte(), 1'b0);
                push_byte(name_byte(), 1'b0);
                push_byte(CHAR_LF, 1'b0);
                overflow_words = words_queued - n;
            end else if ($urandom_range(0, 9) < 7) begin
                first = 1'b1;
                if ($urandom_range(0, 1) == 1) begin
                    push_byte(CHAR_SLASH, 1'b1);
                    push_byte(CHAR_W, 1'b0);
                    repeat ($urandom_range(0, 3)) push_byte(CHAR_SPACE, 1'b0);
                    first = 1'b0;
                end
                n = $urandom_range(0, 20);
                repeat (n) begin
                    b = name_byte();
                    if (first && b == CHAR_SLASH)
                        b = 8'h61;
                    push_byte(b, first);
                    first = 1'b0;
                end
                if ($urandom_range(0, 3) != 0) begin
                    push_byte(CHAR_CR, first);
                    first = 1'b0;
                end
                push_byte(CHAR_LF, first);
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 2)) push_byte(noise_byte(), 1'b0);
            end else begin
                n = $urandom_range(1, 12);
                push_byte(noise_byte(), $urandom_range(0, 9) < 8);
                repeat (n - 1) push_byte(noise_byte(), $urandom_range(0, 15) == 0);
            end
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (bytes_to_send.size() != 0 || s_tvalid || status_due.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
